/* hdl/trirast_pkg.sv */
// Shared types, sizes and codes of the triangle rasterizer.
// Used by trirast_fb, triangle_rasterizer and trirast_chk; no dependencies.
`default_nettype none

package trirast_pkg;

  // Frame buffer geometry
  localparam int unsigned MAX_WIDTH  = 64;
  localparam int unsigned MAX_HEIGHT = 64;
  localparam int unsigned FB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned FB_AW      = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
  localparam int unsigned XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Field widths
  localparam int unsigned CRD_W = 12;   // vertex coordinate, signed
  localparam int unsigned BOX_W = 13;   // clamped box and step values, signed
  localparam int unsigned DIF_W = 14;   // pixel minus vertex, signed
  localparam int unsigned PRD_W = 27;   // one edge product
  localparam int unsigned EDG_W = 28;   // edge function value
  localparam int unsigned COL_W = 8;
  localparam int unsigned PIX_W = 3 * COL_W;
  localparam int unsigned REG_W = 7;    // active size registers
  localparam int unsigned IDX_W = 1;    // register index

  localparam logic [REG_W-1:0] ACT_SIZE_RESET = REG_W'(64);

  // Request codes
  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_ACTIVE_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_ACTIVE_HEIGHT = IDX_W'(1);

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic             en;
    logic [FB_AW-1:0] addr;
    pixel_t           data;
  } fb_wr_t;

  // Linear frame buffer address of pixel (x,y)
  function automatic logic [FB_AW-1:0] fb_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
    return FB_AW'(32'(y) * MAX_WIDTH + 32'(x));
  endfunction

endpackage

`default_nettype wire

/* hdl/trirast_fb.sv */
// Frame buffer memory: one write port, one registered read port.
// Depends on trirast_pkg.
`default_nettype none

module trirast_fb (
  input  wire                                clk_i,
  input  wire  trirast_pkg::fb_wr_t          wr_i,
  input  wire                                rd_en_i,
  input  wire  [trirast_pkg::FB_AW-1:0]      rd_addr_i,
  output trirast_pkg::pixel_t                rd_data_o
);
  import trirast_pkg::*;

  pixel_t mem_q [FB_DEPTH];
  pixel_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* hdl/triangle_rasterizer.sv */
// Edge-function triangle rasterizer with an on-chip RGB frame buffer.
// Depends on trirast_pkg and trirast_fb.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-----------------------------------------
//  cfg     | in  | cfg_we_i                | cfg_idx_i, cfg_data_i
//  in      | in  | in_valid_i / in_ready_o | req_type, x0..y2, fill_*, last_triangle
//  out     | out | out_valid_o/ out_ready_i| read_red/green/blue, batch_done
//
// After reset the frame buffer is zeroed by a sweep over all FB_DEPTH (4096) addresses;
// in_ready_o stays low during it, config writes are taken as usual.
// A read issues the frame buffer read, takes the data back, then posts the
// result. A draw does box setup, then the edge values on the shared edge
// multiplier, then scans the clamped bounding box one pixel per cycle, then
// posts. An empty box goes straight from setup to post.
// One transaction at a time; the result sits in an output register, so a
// stalled output only blocks the next item once its result is due.
`default_nettype none

module triangle_rasterizer (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // configuration
  input  wire                                  cfg_we_i,
  input  wire  [trirast_pkg::IDX_W-1:0]        cfg_idx_i,
  input  wire  [trirast_pkg::REG_W-1:0]        cfg_data_i,
  // request channel
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire                                  req_type_i,
  input  wire  signed [trirast_pkg::CRD_W-1:0] x0_i,
  input  wire  signed [trirast_pkg::CRD_W-1:0] y0_i,
  input  wire  signed [trirast_pkg::CRD_W-1:0] x1_i,
  input  wire  signed [trirast_pkg::CRD_W-1:0] y1_i,
  input  wire  signed [trirast_pkg::CRD_W-1:0] x2_i,
  input  wire  signed [trirast_pkg::CRD_W-1:0] y2_i,
  input  wire  [trirast_pkg::COL_W-1:0]        fill_red_i,
  input  wire  [trirast_pkg::COL_W-1:0]        fill_green_i,
  input  wire  [trirast_pkg::COL_W-1:0]        fill_blue_i,
  input  wire                                  last_triangle_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [trirast_pkg::COL_W-1:0]        read_red_o,
  output logic [trirast_pkg::COL_W-1:0]        read_green_o,
  output logic [trirast_pkg::COL_W-1:0]        read_blue_o,
  output logic                                 batch_done_o
);
  import trirast_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;  // zero sweep after reset
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_BOX   = 3'd2;  // bounding box, clamp, edge steps
  localparam logic [2:0] S_MUL   = 3'd3;  // edge values at box corner
  localparam logic [2:0] S_SCAN  = 3'd4;  // one pixel per cycle
  localparam logic [2:0] S_READ  = 3'd5;  // issue frame buffer read
  localparam logic [2:0] S_RDATA = 3'd6;  // read data back
  localparam logic [2:0] S_DONE  = 3'd7;  // post result

  localparam logic [2:0] MUL_LAST = 3'd6;

  // ---------------------------------------------------------------- state
  logic [2:0]                    state_q, state_d;
  logic [FB_AW-1:0]              clr_q, clr_d;
  logic [REG_W-1:0]              act_w_q, act_h_q;
  logic [2:0]                    cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;

  logic signed [CRD_W-1:0]       vx_q [3], vx_d [3];
  logic signed [CRD_W-1:0]       vy_q [3], vy_d [3];
  pixel_t                        rgb_q, rgb_d;
  logic                          last_q, last_d;
  logic [XW-1:0]                 xmin_q, xmin_d, xmax_q, xmax_d, x_q, x_d;
  logic [YW-1:0]                 ymin_q, ymin_d, ymax_q, ymax_d, y_q, y_d;
  logic signed [BOX_W-1:0]       stx_q [3], stx_d [3];   // E step per +x
  logic signed [BOX_W-1:0]       sty_q [3], sty_d [3];   // E step per -y
  logic signed [EDG_W-1:0]       e_q [3], e_d [3];       // at current pixel
  logic signed [EDG_W-1:0]       er_q [3], er_d [3];     // at row start
  logic signed [PRD_W-1:0]       prod_q, prod_d;
  logic                          rd_ok_q, rd_ok_d;
  pixel_t                        pend_rgb_q, pend_rgb_d;
  logic                          pend_batch_q, pend_batch_d;
  pixel_t                        res_rgb_q, res_rgb_d;
  logic                          res_batch_q, res_batch_d;

  // ---------------------------------------------------------------- frame buffer
  fb_wr_t                        fb_wr;
  logic                          fb_rd_en;
  logic [FB_AW-1:0]              fb_rd_addr;
  pixel_t                        fb_rd_data;

  trirast_fb u_fb (
    .clk_i     (clk_i),
    .wr_i      (fb_wr),
    .rd_en_i   (fb_rd_en),
    .rd_addr_i (fb_rd_addr),
    .rd_data_o (fb_rd_data)
  );

  // ---------------------------------------------------------------- active frame
  // Sizes above the buffer saturate to it.
  logic [REG_W-1:0]              eff_w, eff_h;
  logic signed [BOX_W-1:0]       wm1, hm1;

  assign eff_w = (32'(act_w_q) > MAX_WIDTH)  ? REG_W'(MAX_WIDTH)  : act_w_q;
  assign eff_h = (32'(act_h_q) > MAX_HEIGHT) ? REG_W'(MAX_HEIGHT) : act_h_q;
  assign wm1   = $signed(BOX_W'(eff_w)) - BOX_W'(1);
  assign hm1   = $signed(BOX_W'(eff_h)) - BOX_W'(1);

  // ---------------------------------------------------------------- bounding box
  logic signed [BOX_W-1:0]       bx_min, bx_max, by_min, by_max;
  logic signed [BOX_W-1:0]       xlo, xhi, ylo, yhi;
  logic                          box_empty;

  always_comb begin
    bx_min = BOX_W'(vx_q[0]);
    bx_max = BOX_W'(vx_q[0]);
    by_min = BOX_W'(vy_q[0]);
    by_max = BOX_W'(vy_q[0]);
    for (int k = 1; k < 3; k++) begin
      if (BOX_W'(vx_q[k]) < bx_min) bx_min = BOX_W'(vx_q[k]);
      if (BOX_W'(vx_q[k]) > bx_max) bx_max = BOX_W'(vx_q[k]);
      if (BOX_W'(vy_q[k]) < by_min) by_min = BOX_W'(vy_q[k]);
      if (BOX_W'(vy_q[k]) > by_max) by_max = BOX_W'(vy_q[k]);
    end
    xlo = (bx_min < 0)   ? '0  : bx_min;
    ylo = (by_min < 0)   ? '0  : by_min;
    xhi = (bx_max > wm1) ? wm1 : bx_max;
    yhi = (by_max > hm1) ? hm1 : by_max;
    // a zero size gives a max of -1, below any clamped min
    box_empty = (xhi < xlo) || (yhi < ylo);
  end

  // ---------------------------------------------------------------- shared multiplier
  // Term 2k:   (xmin - ax) * stx[k]
  // Term 2k+1: (ymin - ay) * sty[k], subtracted
  // Edge k runs from vertex (k+1)%3 to vertex (k+2)%3.
  logic signed [DIF_W-1:0]       op_a;
  logic signed [BOX_W-1:0]       op_b;
  logic signed [PRD_W-1:0]       mul_p;
  logic signed [CRD_W-1:0]       va_x, va_y;
  logic signed [BOX_W-1:0]       sel_stx, sel_sty;

  always_comb begin
    case (cnt_q[2:1])
      2'd0: begin
        va_x = vx_q[1]; va_y = vy_q[1]; sel_stx = stx_q[0]; sel_sty = sty_q[0];
      end
      2'd1: begin
        va_x = vx_q[2]; va_y = vy_q[2]; sel_stx = stx_q[1]; sel_sty = sty_q[1];
      end
      default: begin
        va_x = vx_q[0]; va_y = vy_q[0]; sel_stx = stx_q[2]; sel_sty = sty_q[2];
      end
    endcase
    if (cnt_q[0]) begin
      op_a = $signed(DIF_W'(ymin_q)) - DIF_W'(va_y);
      op_b = sel_sty;
    end else begin
      op_a = $signed(DIF_W'(xmin_q)) - DIF_W'(va_x);
      op_b = sel_stx;
    end
    mul_p = op_a * op_b;
  end

  // ---------------------------------------------------------------- pixel test
  logic                          pix_hit;
  assign pix_hit = !e_q[0][EDG_W-1] && !e_q[1][EDG_W-1] && !e_q[2][EDG_W-1];

  // Read bounds
  logic                          rd_in_frame;
  assign rd_in_frame = (vx_q[0] >= 0) && (BOX_W'(vx_q[0]) <= wm1) &&
                       (vy_q[0] >= 0) && (BOX_W'(vy_q[0]) <= hm1);

  // ---------------------------------------------------------------- sequencer
  logic                          in_xfer;
  logic [2:0]                    acc_idx;
  logic [1:0]                    acc_edge;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign acc_idx    = cnt_q - 3'd1;
  assign acc_edge   = acc_idx[2:1];

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    vx_d         = vx_q;
    vy_d         = vy_q;
    rgb_d        = rgb_q;
    last_d       = last_q;
    xmin_d       = xmin_q;
    xmax_d       = xmax_q;
    ymin_d       = ymin_q;
    ymax_d       = ymax_q;
    x_d          = x_q;
    y_d          = y_q;
    stx_d        = stx_q;
    sty_d        = sty_q;
    e_d          = e_q;
    er_d         = er_q;
    prod_d       = prod_q;
    rd_ok_d      = rd_ok_q;
    pend_rgb_d   = pend_rgb_q;
    pend_batch_d = pend_batch_q;
    res_rgb_d    = res_rgb_q;
    res_batch_d  = res_batch_q;

    fb_wr        = '0;
    fb_rd_en     = 1'b0;
    fb_rd_addr   = fb_addr(vx_q[0][XW-1:0], vy_q[0][YW-1:0]);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        fb_wr.en   = 1'b1;
        fb_wr.addr = clr_q;
        fb_wr.data = '0;
        clr_d      = clr_q + FB_AW'(1);
        if (32'(clr_q) == FB_DEPTH - 1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          vx_d[0] = x0_i; vy_d[0] = y0_i;
          vx_d[1] = x1_i; vy_d[1] = y1_i;
          vx_d[2] = x2_i; vy_d[2] = y2_i;
          rgb_d   = {fill_red_i, fill_green_i, fill_blue_i};
          last_d  = last_triangle_i;
          state_d = (req_type_i == REQ_READ) ? S_READ : S_BOX;
        end
      end

      S_BOX: begin
        for (int k = 0; k < 3; k++) begin
          stx_d[k] = BOX_W'(vy_q[(k + 2) % 3]) - BOX_W'(vy_q[(k + 1) % 3]);
          sty_d[k] = BOX_W'(vx_q[(k + 2) % 3]) - BOX_W'(vx_q[(k + 1) % 3]);
        end
        xmin_d = xlo[XW-1:0];
        xmax_d = xhi[XW-1:0];
        ymin_d = ylo[YW-1:0];
        ymax_d = yhi[YW-1:0];
        x_d    = xlo[XW-1:0];
        y_d    = ylo[YW-1:0];
        cnt_d  = '0;
        if (box_empty) begin
          pend_rgb_d   = '0;
          pend_batch_d = last_q;
          state_d      = S_DONE;
        end else begin
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        // product for term cnt, accumulate term cnt-1 from the registered product
        prod_d = mul_p;
        if (cnt_q != 3'd0) begin
          for (int k = 0; k < 3; k++) begin
            if (acc_edge == 2'(k)) begin
              if (acc_idx[0]) begin
                e_d[k]  = e_q[k] - EDG_W'(prod_q);
                er_d[k] = e_q[k] - EDG_W'(prod_q);
              end else begin
                e_d[k]  = EDG_W'(prod_q);
                er_d[k] = EDG_W'(prod_q);
              end
            end
          end
        end
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == MUL_LAST) begin
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        fb_wr.en   = pix_hit;
        fb_wr.addr = fb_addr(x_q, y_q);
        fb_wr.data = rgb_q;
        if (x_q == xmax_q) begin
          if (y_q == ymax_q) begin
            pend_rgb_d   = '0;
            pend_batch_d = last_q;
            state_d      = S_DONE;
          end else begin
            y_d = y_q + YW'(1);
            x_d = xmin_q;
            for (int k = 0; k < 3; k++) begin
              er_d[k] = er_q[k] - EDG_W'(sty_q[k]);
              e_d[k]  = er_q[k] - EDG_W'(sty_q[k]);
            end
          end
        end else begin
          x_d = x_q + XW'(1);
          for (int k = 0; k < 3; k++) begin
            e_d[k] = e_q[k] + EDG_W'(stx_q[k]);
          end
        end
      end

      S_READ: begin
        fb_rd_en = 1'b1;
        rd_ok_d  = rd_in_frame;
        state_d  = S_RDATA;
      end

      S_RDATA: begin
        pend_rgb_d   = rd_ok_q ? fb_rd_data : '0;
        pend_batch_d = 1'b0;
        state_d      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          res_rgb_d   = pend_rgb_q;
          res_batch_d = pend_batch_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      act_w_q     <= ACT_SIZE_RESET;
      act_h_q     <= ACT_SIZE_RESET;
      res_rgb_q   <= '0;
      res_batch_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      res_rgb_q   <= res_rgb_d;
      res_batch_q <= res_batch_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ACTIVE_WIDTH:  act_w_q <= cfg_data_i;
          REG_ACTIVE_HEIGHT: act_h_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q         <= vx_d;
    vy_q         <= vy_d;
    rgb_q        <= rgb_d;
    last_q       <= last_d;
    xmin_q       <= xmin_d;
    xmax_q       <= xmax_d;
    ymin_q       <= ymin_d;
    ymax_q       <= ymax_d;
    x_q          <= x_d;
    y_q          <= y_d;
    stx_q        <= stx_d;
    sty_q        <= sty_d;
    e_q          <= e_d;
    er_q         <= er_d;
    prod_q       <= prod_d;
    rd_ok_q      <= rd_ok_d;
    pend_rgb_q   <= pend_rgb_d;
    pend_batch_q <= pend_batch_d;
  end

  // ---------------------------------------------------------------- outputs
  assign out_valid_o  = out_valid_q;
  assign read_red_o   = res_rgb_q[PIX_W-1 -: COL_W];
  assign read_green_o = res_rgb_q[COL_W +: COL_W];
  assign read_blue_o  = res_rgb_q[COL_W-1:0];
  assign batch_done_o = res_batch_q;

endmodule

`default_nettype wire

/* hdl/trirast_chk.sv */
// Port-level checker for triangle_rasterizer, attached by bind.
// Depends on trirast_pkg and triangle_rasterizer.
`default_nettype none

module trirast_chk (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_valid_i,
  input wire                              in_ready_o,
  input wire                              out_valid_o,
  input wire                              out_ready_i,
  input wire [trirast_pkg::COL_W-1:0]     read_red_o,
  input wire [trirast_pkg::COL_W-1:0]     read_green_o,
  input wire [trirast_pkg::COL_W-1:0]     read_blue_o,
  input wire                              batch_done_o
);
  import trirast_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({read_red_o, read_green_o, read_blue_o, batch_done_o}))
    else $error("result changed while stalled");

  // one transaction in flight: busy right after accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // no result can appear the cycle after accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // batch end only comes from a draw, which returns no color
  a_draw_zero_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && batch_done_o |->
      read_red_o == '0 && read_green_o == '0 && read_blue_o == '0)
    else $error("draw result carries color");

endmodule

bind triangle_rasterizer trirast_chk u_trirast_chk (.*);

`default_nettype wire
